// ----- rtl/lcrt_pkg.sv -----
package lcrt_pkg;

  // window and length sizes
  localparam int VALUE_BITS = 10;
  localparam int LEN_BITS   = VALUE_BITS + 1;
  localparam int DEPTH      = 1 << VALUE_BITS;

  // fixed widths of the channel fields
  localparam int IN_VALUE_W = 10;
  localparam int OUT_LEN_W  = 11;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  localparam val_t VAL_MAX = '1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD1,
    ST_RD2,
    ST_EVAL,
    ST_WR_LO,
    ST_WR_HI,
    ST_OUT
  } state_t;

  // table write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_MID,
    WR_LO,
    WR_HI
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    clr_init;
    logic    rd_right;
    logic    cap_left;
    logic    commit;
    wr_sel_t wr_sel;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic dup;
  } dp_status_t;

endpackage

// ----- rtl/lcrt_if.sv -----
// input channel: one value per beat
interface lcrt_in_if;
  import lcrt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic                  restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

// result channel: one result per beat
interface lcrt_out_if;
  import lcrt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_LEN_W-1:0] run_length;
  logic [OUT_LEN_W-1:0] best_length;
  logic                 duplicate;

  modport source (output valid, output run_length, output best_length, output duplicate,
                  input ready);
  modport sink   (input valid, input run_length, input best_length, input duplicate,
                  output ready);
endinterface

// ----- rtl/lcrt_ram.sv -----
module lcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/lcrt_ctrl.sv -----
module lcrt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_restart,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  lcrt_pkg::dp_status_t   status,
  output lcrt_pkg::dp_cmd_t      cmd
);
  import lcrt_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_restart ? ST_CLEAR : ST_RD1;
        end
      end
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_nxt = pend_r ? ST_RD1 : ST_IDLE;
        end
      end
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = status.dup ? ST_OUT : ST_WR_LO;
      ST_WR_LO: state_nxt = ST_WR_HI;
      ST_WR_HI: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = WR_NONE;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in  = accept;
        cmd.clr_init = accept && in_restart;
      end
      ST_CLEAR: cmd.wr_sel = WR_CLR;
      ST_RD1:   cmd.rd_right = 1'b0;
      ST_RD2: begin
        cmd.rd_right = 1'b1;
        cmd.cap_left = 1'b1;
      end
      ST_EVAL: begin
        cmd.commit = !status.dup;
        cmd.wr_sel = status.dup ? WR_NONE : WR_MID;
      end
      ST_WR_LO: cmd.wr_sel = WR_LO;
      ST_WR_HI: cmd.wr_sel = WR_HI;
      ST_OUT:   cmd.out_load = out_free;
      default:  cmd.wr_sel = WR_NONE;
    endcase
  end

  // pending item across a clearing sweep
  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (state_r == ST_OUT && out_free) begin
      pend_nxt = 1'b0;
    end
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/lcrt_dp.sv -----
module lcrt_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcrt_pkg::val_t        in_value,
  input  lcrt_pkg::dp_cmd_t     cmd,
  output lcrt_pkg::dp_status_t  status,
  output lcrt_pkg::len_t        run_len,
  output lcrt_pkg::len_t        best_len,
  output logic                  dup
);
  import lcrt_pkg::*;

  val_t value_r;
  val_t clr_cnt_r;
  len_t left_r, right_r, total_r;
  len_t best_r;
  logic cur_nz_r;
  len_t run_out_r, best_out_r;
  logic dup_out_r;

  val_t raddr_b;
  len_t rdata_a, rdata_b;
  len_t right_eff;
  len_t total_nxt;
  logic we;
  val_t waddr;
  len_t wdata;

  // read neighbours: left first, then right
  assign raddr_b = cmd.rd_right ? (value_r + val_t'(1)) : (value_r - val_t'(1));

  // merged length, neighbour past the top edge reads as absent
  assign right_eff = (value_r == VAL_MAX) ? '0 : rdata_b;
  assign total_nxt = left_r + right_eff + len_t'(1);

  // table write mux
  always_comb begin
    we    = 1'b1;
    waddr = value_r;
    wdata = total_r;
    unique case (cmd.wr_sel)
      WR_CLR: begin
        waddr = clr_cnt_r;
        wdata = '0;
      end
      WR_MID: wdata = total_nxt;
      WR_LO:  waddr = value_r - left_r[VALUE_BITS-1:0];
      WR_HI:  waddr = value_r + right_r[VALUE_BITS-1:0];
      default: we = 1'b0;
    endcase
  end

  lcrt_ram #(
    .WIDTH (LEN_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (value_r),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // clearing sweep counter and best length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      best_r    <= '0;
    end else begin
      if (cmd.clr_init) begin
        clr_cnt_r <= '0;
        best_r    <= '0;
      end else begin
        if (cmd.wr_sel == WR_CLR) begin
          clr_cnt_r <= clr_cnt_r + val_t'(1);
        end
        if (cmd.commit && total_nxt > best_r) begin
          best_r <= total_nxt;
        end
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      value_r <= in_value;
    end
    if (cmd.cap_left) begin
      cur_nz_r <= (rdata_a != '0);
      left_r   <= (value_r == '0) ? '0 : rdata_b;
    end
    if (cmd.commit) begin
      right_r <= right_eff;
      total_r <= total_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      run_out_r  <= cur_nz_r ? '0 : total_r;
      best_out_r <= best_r;
      dup_out_r  <= cur_nz_r;
    end
  end

  assign status.clr_last = (clr_cnt_r == VAL_MAX);
  assign status.dup      = cur_nz_r;
  assign run_len         = run_out_r;
  assign best_len        = best_out_r;
  assign dup             = dup_out_r;

endmodule

// ----- rtl/longest_consecutive_run_tracker.sv -----
// Longest consecutive run tracker.
// in_bus carries one value per beat plus a restart flag; out_bus returns one
// result per value: the length of the run the value now belongs to (zero for
// a duplicate), the best run so far, and a duplicate flag for a seen value.
// A run-length table of 2^VALUE_BITS entries sits in a RAM with one write
// and two registered read ports. A new value takes three reads (itself and
// both neighbours) and three writes (itself and both ends of the merged
// run) through the single write port. The next beat is accepted only once
// the previous result is loaded; a duplicate skips the writes.
// Restart and reset both run a clearing sweep over all 2^VALUE_BITS entries
// (1024 at the default size), one entry per cycle, with in_ready low; on
// restart the item is then handled against the empty table.
// The result sits in an output register, so a stalled receiver does not
// block the next input beat; only the final step of the following item
// waits until the register is free.
module longest_consecutive_run_tracker (
  input logic      clk,
  input logic      rst_n,
  lcrt_in_if.sink  in_bus,
  lcrt_out_if.source out_bus
);
  import lcrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  len_t       run_len;
  len_t       best_len;
  logic       dup;

  lcrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_restart (in_bus.restart),
    .in_ready   (in_bus.ready),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .status     (status),
    .cmd        (cmd)
  );

  lcrt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (val_t'(in_bus.value)),
    .cmd      (cmd),
    .status   (status),
    .run_len  (run_len),
    .best_len (best_len),
    .dup      (dup)
  );

  assign out_bus.run_length  = OUT_LEN_W'(run_len);
  assign out_bus.best_length = OUT_LEN_W'(best_len);
  assign out_bus.duplicate   = dup;

endmodule

// ----- rtl/lcrt_checker.sv -----
module lcrt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] run_length,
  input logic [10:0] best_length,
  input logic        duplicate
);

  // a duplicate reports no run
  a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && duplicate |-> run_length == '0)
    else $error("duplicate with nonzero run length");

  // a new value always forms a run of at least one
  a_new_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !duplicate |-> run_length != '0)
    else $error("new value with zero run length");

  // best never trails the current run
  a_best_ge_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> best_length >= run_length)
    else $error("best length below run length");

  // one item at a time: input closes after a beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(run_length)
      && $stable(best_length) && $stable(duplicate))
    else $error("stalled result changed");

endmodule

bind longest_consecutive_run_tracker lcrt_checker u_lcrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .run_length  (out_bus.run_length),
  .best_length (out_bus.best_length),
  .duplicate   (out_bus.duplicate)
);
